>>> rtl/core/gregorian_to_lunar_date_top_defines.svh
// ----------------------------------------------------------------------------
// Lunar date converter assertion macros
// Concurrent assertion wrappers, empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_TO_LUNAR_DATE_TOP_DEFINES_SVH
`define GREGORIAN_TO_LUNAR_DATE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define G2L_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define G2L_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define G2L_ASSERT(label, clk, rst_n, prop, msg)
`define G2L_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

>>> rtl/core/g2l_pkg.sv
// ----------------------------------------------------------------------------
// Lunar date converter package
// Payload types, calendar tables and code lookups.
// ----------------------------------------------------------------------------
package g2l_pkg;

  localparam int unsigned YearLo    = 1970;
  localparam int unsigned YearHi    = 2038;
  localparam int unsigned TableBase = 1968;
  localparam int unsigned RomDepth  = 73;
  localparam int unsigned TermRows  = 69;

  typedef struct packed {
    logic [10:0] greg_year;
    logic [3:0]  greg_month;
    logic [4:0]  greg_day;
  } g2l_in_t;

  typedef struct packed {
    logic        valid_res;
    logic [10:0] lunar_year;
    logic [3:0]  lunar_month;
    logic        leap_month;
    logic [4:0]  lunar_day;
    logic [3:0]  stem_index;
    logic [3:0]  branch_index;
    logic [3:0]  holiday_code;
    logic [4:0]  solar_term_code;
    logic [3:0]  festival_code;
  } g2l_out_t;

  // festival start as month (4b) and day (5b)
  typedef struct packed {
    logic [3:0] mon;
    logic [4:0] day;
  } g2l_spring_t;

  localparam logic [15:0] SpringRom [RomDepth] = '{
    16'd130,16'd217,16'd206,16'd127,16'd215,16'd203,16'd123,16'd211,16'd131,16'd218,
    16'd207,16'd128,16'd216,16'd205,16'd125,16'd213,16'd202,16'd220,16'd209,16'd219,
    16'd217,16'd206,16'd127,16'd215,16'd204,16'd123,16'd210,16'd131,16'd219,16'd207,
    16'd128,16'd216,16'd205,16'd124,16'd212,16'd201,16'd122,16'd209,16'd129,16'd218,
    16'd207,16'd126,16'd214,16'd203,16'd123,16'd210,16'd131,16'd219,16'd208,16'd128,
    16'd216,16'd205,16'd125,16'd212,16'd201,16'd122,16'd210,16'd129,16'd217,16'd206,
    16'd126,16'd213,16'd203,16'd123,16'd211,16'd131,16'd219,16'd208,16'd128,16'd215,
    16'd204,16'd124,16'd212};

  localparam logic [19:0] YearRom [RomDepth] = '{
    20'd461653,20'd1386,20'd2413,20'd330077,20'd1197,20'd2637,20'd268877,20'd3365,
    20'd531109,20'd2900,20'd2922,20'd398042,20'd2395,20'd1179,20'd267415,20'd2635,
    20'd661067,20'd1701,20'd1748,20'd398772,20'd2742,20'd2391,20'd330031,20'd1175,
    20'd1611,20'd200010,20'd3749,20'd527717,20'd1452,20'd2742,20'd332397,20'd2350,
    20'd3222,20'd268949,20'd3402,20'd3493,20'd133973,20'd1386,20'd464219,20'd605,
    20'd2349,20'd334123,20'd2709,20'd2890,20'd267946,20'd2773,20'd592565,20'd1210,
    20'd2651,20'd395863,20'd1323,20'd2707,20'd265877,20'd1706,20'd2773,20'd133557,
    20'd1206,20'd398510,20'd2638,20'd3366,20'd335142,20'd3411,20'd1450,20'd200042,
    20'd2413,20'd723293,20'd1197,20'd2637,20'd399947,20'd3365,20'd3410,20'd334676,
    20'd2906};

  localparam logic [95:0] TermRom [TermRows] = '{
    96'h95B496A5969788787869_7887,96'h96B496A6979778797969_7877,
    96'h96A4A5A5A6A688888878_8787,96'hA5B596A5A69688787878_8787,
    96'h95B496A5969788787869_7887,96'h96B496A6979778797869_7877,
    96'h96A4A5B5A6A688898878_8787,96'hA5B496A5969688887878_8787,
    96'h95B496A5969788787879_7887,96'h96B496A6969778797869_7877,
    96'h96A4A5B5A6A688888878_8787,96'hA5B496A5A69688887878_7787,
    96'h95B496A5969788787879_7787,96'h95B496A5969778797869_7877,
    96'h96B4A5B5A6A687888878_8787,96'hA5B4A6A5A69688887878_8787,
    96'hA5B496A5969788787879_7787,96'h95B496A5969788797869_7887,
    96'h96B4A5B5A6A687888878_8786,96'hA5B4A5A5A69688888878_8787,
    96'hA5B496A5969688787879_7787,96'h95B496A5869788787869_7887,
    96'h96B4A5B5A6A687888878_8786,96'hA5B3A5A5A69688888878_8787,
    96'hA5B496A5969688787878_8787,96'h95B496A5969788767869_7887,
    96'h96B4A5B5A6A687888878_8786,96'hA5B3A5A5A6A688888878_8787,
    96'hA5B496A5969688787878_8787,96'h95B496A5969788787869_7887,
    96'h96B4A5B5A6A687888878_8786,96'hA5B3A5A5A6A688888878_8787,
    96'hA5B496A5969688787878_8787,96'h95B496A5969788787869_7887,
    96'h96B4A5B5A6A687888878_8786,96'hA5B3A5A5A6A688888878_8787,
    96'hA5B496A5A69688887878_8787,96'h95B496A5969788787869_7887,
    96'h96B4A5B5A6A687888778_8786,96'hA5B3A5B5A6A688888878_8787,
    96'hA5B496A5A69688887878_8787,96'h95B496A5969788787879_7887,
    96'h96B4A5B5A5A687888778_8786,96'hA5B3A5B5A6A687888878_8787,
    96'hA5B496A5A69688887878_8787,96'h95B496A5969788787879_7787,
    96'h95B4A5B4A5A687888778_8786,96'hA5C3A5B5A6A687888878_8787,
    96'hA5B4A6A5A69688887878_8787,96'hA5B496A5969688787879_7787,
    96'h95B4A5B4A5A697878778_8786,96'hA5C3A5B5A6A687888878_8786,
    96'hA5B4A5A5A69688888878_8787,96'hA5B496A5969688787879_7787,
    96'h95B4A5B4A5A697878778_8796,96'hA5C3A5B5A6A687888878_8786,
    96'hA5B3A5A5A6A688888878_8787,96'hA5B496A5969688787878_8787,
    96'h95B4A5B4A5A697878778_8796,96'hA5C3A5B5A6A687888878_8786,
    96'hA5B3A5A5A6A688888878_8787,96'hA5B496A5969688787878_8787,
    96'h95B4A5B4A5A697878778_8796,96'hA5C3A5B5A6A688888878_8786,
    96'hA5B3A5A5A6A688788878_8787,96'hA5B496A5A69688887878_8787,
    96'h95B4A5B4A5A697878778_8796,96'hA5C3A5B5A6A687888878_8786,
    96'hA5B3A5A5A6A688888878_8787};

  localparam logic [8:0] MonthStartRom [12] = '{
    9'd0,9'd31,9'd59,9'd90,9'd120,9'd151,9'd181,9'd212,9'd243,9'd273,9'd304,9'd334};

  function automatic g2l_spring_t spring_date(input logic [6:0] idx);
    logic [15:0] v;
    g2l_spring_t s;
    v = SpringRom[idx];
    s.mon = (v >= 16'd200) ? 4'd2 : 4'd1;
    s.day = (v >= 16'd200) ? 5'(v - 16'd200) : 5'(v - 16'd100);
    return s;
  endfunction

  function automatic logic [7:0] term_offset(input logic [6:0] row, input logic [3:0] mon);
    logic [95:0] r;
    r = TermRom[row];
    return r[8*(12-int'(mon)) +: 8];
  endfunction

  function automatic logic [3:0] holiday_lookup(input logic [3:0] m, input logic [4:0] d);
    logic [3:0] c;
    c = '0;
    unique case ({m, d})
      {4'd1, 5'd1}:   c = 4'd1;
      {4'd2, 5'd14}:  c = 4'd2;
      {4'd3, 5'd8}:   c = 4'd3;
      {4'd4, 5'd1}:   c = 4'd4;
      {4'd5, 5'd1}:   c = 4'd5;
      {4'd5, 5'd4}:   c = 4'd6;
      {4'd6, 5'd1}:   c = 4'd7;
      {4'd7, 5'd1}:   c = 4'd8;
      {4'd8, 5'd1}:   c = 4'd9;
      {4'd9, 5'd10}:  c = 4'd10;
      {4'd10, 5'd1}:  c = 4'd11;
      {4'd12, 5'd24}: c = 4'd12;
      default:        c = 4'd0;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] festival_lookup(input logic [3:0] m, input logic [4:0] d);
    logic [3:0] c;
    c = '0;
    unique case ({m, d})
      {4'd1, 5'd1}:   c = 4'd1;
      {4'd1, 5'd15}:  c = 4'd2;
      {4'd2, 5'd2}:   c = 4'd3;
      {4'd5, 5'd5}:   c = 4'd4;
      {4'd7, 5'd7}:   c = 4'd5;
      {4'd8, 5'd15}:  c = 4'd6;
      {4'd9, 5'd9}:   c = 4'd7;
      {4'd12, 5'd8}:  c = 4'd8;
      default:        c = 4'd0;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/g2l_walk.sv
// ----------------------------------------------------------------------------
// Lunar month walker
// Subtracts one month length per cycle from the day count, pausing per year.
// ----------------------------------------------------------------------------
module g2l_walk
  import g2l_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [6:0]  start_idx,
  input  logic [9:0]  start_cnt,
  output logic        done,
  output logic        found,
  output logic [6:0]  idx,
  output logic [3:0]  k_out,
  output logic [3:0]  n_out,
  output logic [9:0]  cnt_out
);

  typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_STEP} walk_st_t;

  walk_st_t    st_r;
  logic [6:0]  idx_r;
  logic [9:0]  cnt_r;
  logic [3:0]  n_r, k_r;
  logic        done_r, found_r;
  logic [19:0] data;
  logic [9:0]  len;

  assign data = YearRom[idx_r];
  assign len  = 10'd29 + 10'(data[n_r]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      found_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      unique case (st_r)
        ST_IDLE: begin
          done_r <= 1'b0;
          if (start) begin
            idx_r <= start_idx;
            cnt_r <= start_cnt;
            st_r  <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (idx_r >= 7'(RomDepth)) begin
            found_r <= 1'b0;
            done_r  <= 1'b1;
            st_r    <= ST_IDLE;
          end else begin
            done_r <= 1'b0;
            k_r    <= (data < 20'd4095) ? 4'd11 : 4'd12;
            n_r    <= (data < 20'd4095) ? 4'd11 : 4'd12;
            st_r   <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (cnt_r <= len) begin
            found_r <= 1'b1;
            done_r  <= 1'b1;
            st_r    <= ST_IDLE;
          end else begin
            done_r <= 1'b0;
            cnt_r  <= cnt_r - len;
            if (n_r == 4'd0) begin
              idx_r <= idx_r + 7'd1;
              st_r  <= ST_LOAD;
            end else begin
              n_r <= n_r - 4'd1;
            end
          end
        end
        default: begin
          done_r <= 1'b0;
          st_r   <= ST_IDLE;
        end
      endcase
    end
  end

  assign done    = done_r;
  assign found   = found_r;
  assign idx     = idx_r;
  assign k_out   = k_r;
  assign n_out   = n_r;
  assign cnt_out = cnt_r;

endmodule

>>> rtl/core/gregorian_to_lunar_date_top.sv
// ----------------------------------------------------------------------------
// Gregorian to lunar date converter
// Table-driven conversion of a 1970..2038 date to the Chinese lunar date.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_data carries one Gregorian date.
//   Result channel out_valid/out_stall/out_data returns one result per date.
//   in_stall is high while a date is being converted or its result waits.
//   From the input transfer, the date is registered, range-checked in
//   the prep state and handed to the month walker, which loads the table
//   entry of each lunar year and walks its months; the result is then
//   registered and out_valid rises. The walk starts at the festival on or
//   before the date. The month walker does one subtract and compare a
//   cycle, pausing at each lunar year boundary to load the next entry.
//   An out-of-range date skips the walk and returns valid_res = 0 with
//   all other fields zero, set in the prep state without a walk.
//   The result register holds while out_stall is high; the next date is
//   taken only after the result transfers.
//   Reset (rst_n low, synchronous) drops any date in flight and clears
//   out_valid.
// ----------------------------------------------------------------------------
`include "gregorian_to_lunar_date_top_defines.svh"

module gregorian_to_lunar_date_top
  import g2l_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  g2l_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output g2l_out_t out_data
);

  typedef enum logic [2:0] {ST_IDLE, ST_PREP, ST_WALK, ST_DONE, ST_OUT} top_st_t;

  top_st_t     st_r;
  g2l_in_t     req_r;
  g2l_out_t    res_r;
  logic        out_valid_r;
  logic        range_ok;
  logic [6:0]  yidx;
  g2l_spring_t sp;
  logic        pre_festival;
  logic [6:0]  fidx;
  g2l_spring_t fsp;
  logic [10:0] base_cnt;
  logic [10:0] cnt_calc;
  logic        walk_start;
  logic        w_done, w_found;
  logic [6:0]  w_idx;
  logic [3:0]  w_k, w_n;
  logic [9:0]  w_cnt;
  logic [19:0] wdata;
  logic [3:0]  lmon0, lmon, leapm;
  logic        leap;
  logic [4:0]  lday;
  logic [10:0] lyear;
  logic [6:0]  cyc;
  logic [14:0] q10_prod;
  logic [3:0]  q10;
  logic [8:0]  q12_prod;
  logic [3:0]  q12;
  logic [6:0]  stem_full, branch_full;
  logic [7:0]  tb;
  logic [4:0]  term;
  logic [6:0]  ridx;

  assign range_ok = (req_r.greg_year >= 11'(YearLo)) && (req_r.greg_year <= 11'(YearHi)) &&
                    (req_r.greg_month >= 4'd1) && (req_r.greg_month <= 4'd12) &&
                    (req_r.greg_day != 5'd0);
  assign yidx   = 7'(req_r.greg_year - 11'(TableBase));
  assign sp     = spring_date(yidx);
  assign pre_festival = (req_r.greg_month < sp.mon) ||
                        ((req_r.greg_month == sp.mon) && (req_r.greg_day < sp.day));
  assign fidx   = pre_festival ? yidx - 7'd1 : yidx;
  assign fsp    = spring_date(fidx);
  // day + start(month) - 31*(sm-1) - sd + 1, biased positive by the festival window
  assign base_cnt = 11'(req_r.greg_day) + 11'(MonthStartRom[req_r.greg_month - 4'd1])
                    + 11'd1 - ((fsp.mon == 4'd2) ? 11'd31 : 11'd0) - 11'(fsp.day);
  always_comb begin
    cnt_calc = base_cnt;
    if (pre_festival) begin
      cnt_calc = cnt_calc + 11'd365;
      if (req_r.greg_year[1:0] == 2'd1) cnt_calc = cnt_calc + 11'd1;
    end
    if ((req_r.greg_year[1:0] == 2'd0) && (req_r.greg_month > 4'd2))
      cnt_calc = cnt_calc + 11'd1;
  end

  assign walk_start = (st_r == ST_PREP) && range_ok;

  g2l_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (walk_start),
    .start_idx (fidx),
    .start_cnt (cnt_calc[9:0]),
    .done      (w_done),
    .found     (w_found),
    .idx       (w_idx),
    .k_out     (w_k),
    .n_out     (w_n),
    .cnt_out   (w_cnt)
  );

  assign ridx  = w_found ? w_idx : 7'(RomDepth - 1);
  assign wdata = YearRom[ridx];
  assign leapm = wdata[19:16];
  always_comb begin
    lmon0 = w_found ? (w_k - w_n + 4'd1) : 4'd12;
    lmon  = lmon0;
    leap  = 1'b0;
    if (w_found && (w_k == 4'd12)) begin
      if (lmon0 == leapm + 4'd1) begin
        lmon = lmon0 - 4'd1;
        leap = 1'b1;
      end else if (lmon0 > leapm + 4'd1) begin
        lmon = lmon0 - 4'd1;
      end
    end
  end
  assign lday  = w_found ? w_cnt[4:0] : 5'd1;
  assign lyear = 11'(TableBase) + 11'(ridx);
  assign cyc   = 7'(lyear - 11'd1924);

  // stem and branch: divide by 10 and 12 through reciprocal multiplies,
  // exact over the 7-bit cycle range
  assign q10_prod    = 15'(cyc) * 15'd205;
  assign q10         = q10_prod[14:11];
  assign stem_full   = cyc - 7'({q10, 3'b000}) - 7'({q10, 1'b0});
  assign q12_prod    = 9'(cyc[6:2]) * 9'd11;
  assign q12         = q12_prod[8:5];
  assign branch_full = cyc - 7'({q12, 3'b000}) - 7'({q12, 2'b00});

  assign tb    = term_offset(7'(req_r.greg_year - 11'(YearLo)), req_r.greg_month);
  always_comb begin
    term = 5'd0;
    if ((req_r.greg_day < 5'd15) && ({1'b0, tb[7:4]} == 5'd15 - req_r.greg_day))
      term = 5'({req_r.greg_month - 4'd1, 1'b0} + 5'd1);
    else if ((req_r.greg_day > 5'd15) && ({1'b0, tb[3:0]} == req_r.greg_day - 5'd15))
      term = 5'({req_r.greg_month - 4'd1, 1'b0} + 5'd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (st_r)
        ST_IDLE: begin
          if (in_valid) begin
            req_r <= in_data;
            st_r  <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (range_ok) begin
            st_r <= ST_WALK;
          end else begin
            res_r       <= '0;
            out_valid_r <= 1'b1;
            st_r        <= ST_OUT;
          end
        end
        ST_WALK: begin
          if (w_done) st_r <= ST_DONE;
        end
        ST_DONE: begin
          res_r.valid_res       <= 1'b1;
          res_r.lunar_year      <= lyear;
          res_r.lunar_month     <= lmon;
          res_r.leap_month      <= leap;
          res_r.lunar_day       <= lday;
          res_r.stem_index      <= stem_full[3:0];
          res_r.branch_index    <= branch_full[3:0];
          res_r.holiday_code    <= holiday_lookup(req_r.greg_month, req_r.greg_day);
          res_r.solar_term_code <= term;
          res_r.festival_code   <= festival_lookup(lmon, lday);
          out_valid_r           <= 1'b1;
          st_r                  <= ST_OUT;
        end
        ST_OUT: begin
          // hold until the result transfers
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            st_r        <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall  = (st_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  `G2L_ASSERT(a_out_only_in_out, clk, rst_n, out_valid |-> (st_r == ST_OUT), "out_valid outside output state")
  `G2L_ASSERT(a_busy_stall, clk, rst_n, out_valid |-> in_stall, "input taken while result pending")
  `G2L_ASSERT(a_walk_done, clk, rst_n, w_done |-> (st_r == ST_WALK), "walker finished while not walking")
  `G2L_ASSERT_RST(a_reset_clear, clk, !rst_n |=> !out_valid, "out_valid after reset")

endmodule

>>> dv/g2l_date_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lunar date converter checker
// Watches both channels, predicts each lunar date from the accepted Gregorian
// date and compares every result field with the oldest prediction.
// ----------------------------------------------------------------------------
module g2l_date_checker
  import g2l_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  g2l_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  g2l_out_t out_data,
  output int       fail_count,
  output int       pending_dates
);

  g2l_out_t lunar_dates_q[$];

  localparam logic [8:0] HolidayKeys [12] = '{
    {4'd1, 5'd1}, {4'd2, 5'd14}, {4'd3, 5'd8}, {4'd4, 5'd1}, {4'd5, 5'd1}, {4'd5, 5'd4},
    {4'd6, 5'd1}, {4'd7, 5'd1}, {4'd8, 5'd1}, {4'd9, 5'd10}, {4'd10, 5'd1}, {4'd12, 5'd24}};
  localparam logic [8:0] FestivalKeys [8] = '{
    {4'd1, 5'd1}, {4'd1, 5'd15}, {4'd2, 5'd2}, {4'd5, 5'd5},
    {4'd7, 5'd7}, {4'd8, 5'd15}, {4'd9, 5'd9}, {4'd12, 5'd8}};

  initial fail_count = 0;
  assign pending_dates = lunar_dates_q.size();

  // Day number counted from the festival of table entry idx, 1 = festival.
  function automatic int day_after_festival(int idx, int mon, int day);
    int sm, sd;
    sm = int'(SpringRom[idx]) / 100;
    sd = int'(SpringRom[idx]) % 100;
    return day + int'(MonthStartRom[mon - 1]) - 31 * (sm - 1) - sd + 1;
  endfunction

  function automatic g2l_out_t predict_lunar_date(g2l_in_t g);
    g2l_out_t r;
    int yr, mon, day, idx, k, n, cnt, lmon, lyr, leapm, len, sm, sd, tb;
    logic [19:0] bits;
    bit hit;
    r = '0;
    yr = g.greg_year;
    mon = g.greg_month;
    day = g.greg_day;
    k = 11;
    n = 0;
    bits = '0;
    hit = 0;
    if (yr < YearLo || yr > YearHi || mon < 1 || mon > 12 || day < 1) return r;
    idx = yr - TableBase;
    sm = int'(SpringRom[idx]) / 100;
    sd = int'(SpringRom[idx]) % 100;
    if (mon < sm || (mon == sm && day < sd)) begin
      idx--;
      cnt = 365 + day_after_festival(idx, mon, day);
      if (yr % 4 == 0 && mon > 2) cnt++;
      if ((yr - 1) % 4 == 0) cnt++;
    end else begin
      cnt = day_after_festival(idx, mon, day);
      if (yr % 4 == 0 && mon > 2) cnt++;
    end
    while (idx < RomDepth && !hit) begin
      bits = YearRom[idx];
      k = (bits < 4095) ? 11 : 12;
      for (n = k; n >= 0; n--) begin
        len = 29 + int'(bits[n]);
        if (cnt <= len) begin
          hit = 1;
          break;
        end
        cnt -= len;
      end
      if (!hit) idx++;
    end
    if (!hit) begin
      idx = RomDepth - 1;
      n = 0;
      cnt = 1;
    end
    lyr = TableBase + idx;
    lmon = k - n + 1;
    if (k == 12) begin
      leapm = int'(bits >> 16);
      if (lmon == leapm + 1) begin
        lmon--;
        r.leap_month = 1'b1;
      end else if (lmon > leapm + 1) begin
        lmon--;
      end
    end
    r.valid_res = 1'b1;
    r.lunar_year = 11'(lyr);
    r.lunar_month = 4'(lmon);
    r.lunar_day = 5'(cnt);
    r.stem_index = 4'((lyr - 1924) % 10);
    r.branch_index = 4'((lyr - 1924) % 12);
    for (int i = 0; i < 12; i++)
      if (HolidayKeys[i] == {4'(mon), 5'(day)}) r.holiday_code = 4'(i + 1);
    tb = int'(TermRom[yr - YearLo][8*(12-mon) +: 8]);
    if (day < 15 && (tb >> 4) == 15 - day) r.solar_term_code = 5'(2 * (mon - 1) + 1);
    else if (day > 15 && (tb & 'h0f) == day - 15) r.solar_term_code = 5'(2 * (mon - 1) + 2);
    for (int i = 0; i < 8; i++)
      if (FestivalKeys[i] == {4'(lmon), 5'(cnt)}) r.festival_code = 4'(i + 1);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    g2l_out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) lunar_dates_q.push_back(predict_lunar_date(in_data));
      if (out_valid && !out_stall) begin
        if (lunar_dates_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = lunar_dates_q.pop_front();
          if (out_data.valid_res != want.valid_res)
            report_mismatch("valid_res", out_data.valid_res, want.valid_res);
          if (out_data.lunar_year != want.lunar_year)
            report_mismatch("lunar_year", out_data.lunar_year, want.lunar_year);
          if (out_data.lunar_month != want.lunar_month)
            report_mismatch("lunar_month", out_data.lunar_month, want.lunar_month);
          if (out_data.leap_month != want.leap_month)
            report_mismatch("leap_month", out_data.leap_month, want.leap_month);
          if (out_data.lunar_day != want.lunar_day)
            report_mismatch("lunar_day", out_data.lunar_day, want.lunar_day);
          if (out_data.stem_index != want.stem_index)
            report_mismatch("stem_index", out_data.stem_index, want.stem_index);
          if (out_data.branch_index != want.branch_index)
            report_mismatch("branch_index", out_data.branch_index, want.branch_index);
          if (out_data.holiday_code != want.holiday_code)
            report_mismatch("holiday_code", out_data.holiday_code, want.holiday_code);
          if (out_data.solar_term_code != want.solar_term_code)
            report_mismatch("solar_term_code", out_data.solar_term_code,
                            want.solar_term_code);
          if (out_data.festival_code != want.festival_code)
            report_mismatch("festival_code", out_data.festival_code, want.festival_code);
        end
      end
    end
  end

endmodule

>>> dv/gregorian_to_lunar_date_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lunar date converter testbench
// Drives directed and random Gregorian dates with random gaps and result
// stalls, including a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module gregorian_to_lunar_date_top_tb;
  import g2l_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  g2l_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  g2l_out_t out_data;
  int       fail_count;
  int       pending_dates;
  bit       hold_off_req;
  bit       sending_done;

  gregorian_to_lunar_date_top u_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data));

  g2l_date_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data), .fail_count(fail_count), .pending_dates(pending_dates));

  initial clk = 0;
  always #6 clk = ~clk;

  task automatic send_date(int yr, int mon, int day);
    int gap;
    gap = $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= '{greg_year: 11'(yr), greg_month: 4'(mon), greg_day: 5'(day)};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // drop valid before a pause so no date is offered twice
  task automatic idle_input();
    in_valid <= 1'b0;
  endtask

  task automatic send_random_date();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85)
      send_date($urandom_range(YearLo, YearHi), $urandom_range(1, 12), $urandom_range(1, 31));
    else if (r < 95)
      send_date($urandom_range(0, 2047), $urandom_range(0, 15), $urandom_range(0, 31));
    else
      // spring festival neighborhood
      send_date($urandom_range(YearLo, YearHi), $urandom_range(1, 2), $urandom_range(15, 31));
  endtask

  // Result side: random wait per result, plus one long hold-off on request.
  initial begin
    int gap;
    out_stall = 1'b1;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        hold_off_req = 0;
      end
      gap = $urandom_range(0, 18);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    hold_off_req = 0;
    sending_done = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    // directed: field extremes, out-of-range cases, overflow days, leap years
    send_date(YearLo, 1, 1);
    send_date(YearHi, 12, 31);
    send_date(YearHi, 12, 24);
    send_date(1969, 6, 1);
    send_date(2039, 6, 1);
    send_date(2047, 15, 31);
    send_date(0, 0, 0);
    send_date(2000, 0, 10);
    send_date(2000, 13, 10);
    send_date(2000, 5, 0);
    send_date(2001, 2, 30);
    send_date(2001, 12, 31);
    send_date(2000, 2, 29);
    send_date(2020, 3, 1);
    send_date(2017, 7, 1);
    send_date(1984, 2, 2);
    send_date(2033, 12, 22);
    send_date(1990, 9, 15);
    send_date(2012, 6, 15);
    send_date(1976, 1, 30);
    send_date(1993, 1, 1);
    send_date(2024, 2, 10);
    // long output hold-off while dates keep coming
    hold_off_req = 1;
    repeat (10) send_random_date();
    idle_input();
    do @(negedge clk); while (hold_off_req);
    for (int i = 0; i < 920; i++) begin
      send_random_date();
      if (i == 400) begin
        idle_input();
        do @(negedge clk); while (pending_dates != 0);
      end
    end
    idle_input();
    do @(negedge clk); while (pending_dates != 0);
    sending_done = 1;
    repeat (30) @(negedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #3ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
